### rtl/cil_pkg.sv
// ----------------------------------------------------------------------------
// cil_pkg
// Shared request codes and cell control type for the compacting list.
// ----------------------------------------------------------------------------
package cil_pkg;

  // request kinds
  localparam logic [2:0] ModeAppend = 3'd0;
  localparam logic [2:0] ModeGet    = 3'd1;
  localparam logic [2:0] ModeSet    = 3'd2;
  localparam logic [2:0] ModePop    = 3'd3;
  localparam logic [2:0] ModeDelete = 3'd4;

  // per-cell update control
  typedef struct packed {
    logic load;   // take the request word
    logic shift;  // take the upper neighbor's word
  } cell_ctrl_t;

endpackage

### rtl/cil_cell.sv
// ----------------------------------------------------------------------------
// cil_cell
// One list slot: holds a word, loads a new one or takes its upper neighbor's.
// ----------------------------------------------------------------------------
module cil_cell
  import cil_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic [DATA_WIDTH-1:0] upper_data_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // select next contents
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = wr_data_i;
    end else if (ctrl_i.shift) begin
      data_d = upper_data_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/compacting_indexed_list_core.sv
// ----------------------------------------------------------------------------
// compacting_indexed_list_core
// Ordered word list with append, get, set, pop and delete-with-compaction.
// ----------------------------------------------------------------------------
// The list is a row of DEPTH cells, one word each. When a request is taken,
// all cells update together, so a delete closes its gap as each cell from
// the index up copies its upper neighbor. The result sits in an output
// register and a new request is taken while it waits, so the block sustains
// one request per cycle; in_stall_o rises only while a result is held and
// the output side stalls. Every request returns exactly one result with the
// read word, a fail flag and the count afterwards. The user writes the
// capacity register via cfg_we_i/cfg_data_i only while idle (not enforced).
// ----------------------------------------------------------------------------
module compacting_indexed_list_core
  import cil_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // capacity register
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_mode_i,
  input  logic [4:0]  in_index_i,
  input  logic [31:0] in_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_read_value_o,
  output logic        out_status_o,
  output logic [4:0]  out_entry_count_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 5) ? CW : 5;

  logic [CW-1:0] count_q, count_d;
  logic [4:0]    cap_q;
  logic          out_valid_q;
  logic [31:0]   rd_q;
  logic          status_q;
  logic [4:0]    ecount_q;

  logic                  accept;
  logic [IW-1:0]         idx_w, cnt_w, cap_w, depth_w, rd_idx;
  logic                  idx_ok, append_ok, pop_ok;
  logic                  fail;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;
  logic [63:0]           val64, rd64;
  logic [15:0]           cnt16;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  cell_ctrl_t            cell_ctrl [DEPTH];

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  // common compares
  assign idx_w     = IW'(in_index_i);
  assign cnt_w     = IW'(count_q);
  assign cap_w     = IW'(cap_q);
  assign depth_w   = IW'(DEPTH);
  assign idx_ok    = (idx_w < cnt_w);
  assign append_ok = (cnt_w < cap_w) && (cnt_w < depth_w);
  assign pop_ok    = (cnt_w != '0);

  assign val64   = 64'(in_value_i);
  assign wr_data = val64[DATA_WIDTH-1:0];

  // status and count update
  always_comb begin
    fail    = 1'b1;
    count_d = count_q;
    rd_idx  = idx_w;
    case (in_mode_i)
      ModeAppend: begin
        fail = !append_ok;
        if (append_ok) count_d = count_q + CW'(1);
      end
      ModeGet: fail = !idx_ok;
      ModeSet: fail = !idx_ok;
      ModePop: begin
        fail   = !pop_ok;
        rd_idx = cnt_w - IW'(1);
        if (pop_ok) count_d = count_q - CW'(1);
      end
      ModeDelete: begin
        fail = !idx_ok;
        if (idx_ok) count_d = count_q - CW'(1);
      end
      default: fail = 1'b1;
    endcase
  end

  // per-cell controls
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].load  = 1'b0;
      cell_ctrl[i].shift = 1'b0;
      if (accept && !fail) begin
        case (in_mode_i)
          ModeAppend: cell_ctrl[i].load = (IW'(i) == cnt_w);
          ModeSet:    cell_ctrl[i].load = (IW'(i) == idx_w);
          ModeDelete: cell_ctrl[i].shift = (IW'(i) >= idx_w) && (IW'(i + 1) < cnt_w);
          default: begin
            cell_ctrl[i].load  = 1'b0;
            cell_ctrl[i].shift = 1'b0;
          end
        endcase
      end
    end
  end

  // row of cells, each fed by its upper neighbor (the top cell by itself)
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;
    if (g == DEPTH - 1) begin : g_top
      assign upper = cell_data[g];
    end else begin : g_mid
      assign upper = cell_data[g + 1];
    end
    cil_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .wr_data_i   (wr_data),
      .upper_data_i(upper),
      .data_o      (cell_data[g])
    );
  end

  // read select: and-or over the cells
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IW'(i) == rd_idx) rd_data = rd_data | cell_data[i];
    end
    if (fail || !((in_mode_i == ModeGet) || (in_mode_i == ModePop))) begin
      rd_data = '0;
    end
  end

  assign rd64  = 64'(rd_data);
  assign cnt16 = 16'(count_d);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= 5'd16;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd64[31:0];
      status_q <= fail;
      ecount_q <= cnt16[4:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_value_o  = rd_q;
  assign out_status_o      = status_q;
  assign out_entry_count_o = ecount_q;

endmodule

### dv/compacting_indexed_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_indexed_list_core_tb
// Self-checking testbench for the compacting word list.
// ----------------------------------------------------------------------------
// Requests go in through the valid/stall request channel. Each accepted
// request is run through a behavioral copy of the list, and the expected
// result is queued. Every accepted result is checked field by field against
// the oldest queued one. Directed tests cover the empty list, the full list,
// index bounds, compaction on delete and capacity changes. Random traffic
// then runs under several capacity settings, with random idling on both sides except in one steady phase.
// ----------------------------------------------------------------------------
module compacting_indexed_list_core_tb;
  import cil_pkg::*;

  localparam int Depth = 16;
  localparam int ClkPeriod = 12;
  localparam int IdlePercent = 9;
  localparam int ItemsPerPhase = 180;
  localparam int MaxPrinted = 40;
  localparam logic [2:0] ModeTop = 3'd7;  // highest mode encoding
  localparam logic StatusDone = 1'b0;
  localparam logic StatusFail = 1'b1;

  typedef struct {
    logic [31:0] read_value;
    logic        status;
    logic [4:0]  entry_count;
  } list_result_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  in_mode_i = ModeAppend;
  logic [4:0]  in_index_i = '0;
  logic [31:0] in_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_read_value_o;
  logic        out_status_o;
  logic [4:0]  out_entry_count_o;

  // predicted list contents and capacity register
  logic [31:0]  list_words [Depth];
  int unsigned  list_count;
  logic [4:0]   capacity_reg;
  list_result_t pending_results [$];

  // bookkeeping
  bit steady = 1'b0;  // suppresses idling on both sides
  int mismatch_count = 0;
  int results_seen = 0;
  int fails_seen = 0;
  int requests_sent = 0;

  compacting_indexed_list_core #(
    .DEPTH     (Depth),
    .DATA_WIDTH(32)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_mode_i        (in_mode_i),
    .in_index_i       (in_index_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_read_value_o (out_read_value_o),
    .out_status_o     (out_status_o),
    .out_entry_count_o(out_entry_count_o)
  );

  // clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("Timeout: results still outstanding: %0d", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  // updates the list for one request and returns what the block should answer
  function automatic list_result_t apply_request(logic [2:0] mode, logic [4:0] index,
                                                 logic [31:0] value);
    list_result_t res;
    int unsigned  usable;
    res.read_value = '0;
    res.status = StatusDone;
    usable = (capacity_reg > Depth) ? Depth : capacity_reg;
    case (mode)
      ModeAppend: begin
        if (list_count < usable) begin
          list_words[list_count] = value;
          list_count++;
        end else res.status = StatusFail;
      end
      ModeGet: begin
        if (index < list_count) res.read_value = list_words[index];
        else res.status = StatusFail;
      end
      ModeSet: begin
        if (index < list_count) list_words[index] = value;
        else res.status = StatusFail;
      end
      ModePop: begin
        if (list_count > 0) begin
          res.read_value = list_words[list_count - 1];
          list_count--;
        end else res.status = StatusFail;
      end
      ModeDelete: begin
        // later entries close the gap
        if (index < list_count) begin
          for (int i = index; i + 1 < list_count; i++) list_words[i] = list_words[i + 1];
          list_count--;
        end else res.status = StatusFail;
      end
      default: res.status = StatusFail;
    endcase
    res.entry_count = list_count[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MaxPrinted)
      $display("[%0t] error: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result check first, then prediction for a request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_count <= 0;
      capacity_reg <= 5'd16;
      pending_results.delete();
    end else begin
      list_result_t want;
      list_result_t got;
      if (out_valid_o && !out_stall_i) begin
        got.read_value = out_read_value_o;
        got.status = out_status_o;
        got.entry_count = out_entry_count_o;
        results_seen++;
        if (got.status == StatusFail) fails_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending, count", {27'b0, got.entry_count},
                          '0);
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.status !== want.status)
            report_mismatch("status", {31'b0, got.status}, {31'b0, want.status});
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", {27'b0, got.entry_count},
                            {27'b0, want.entry_count});
        end
      end
      if (cfg_we_i) capacity_reg <= cfg_data_i;
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(apply_request(in_mode_i, in_index_i, in_value_i));
    end
  end

  // output side stalls at random unless steady
  always @(posedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(0, 99) < IdlePercent);
  end

  // sends one request, with a random gap ahead of it, and waits for acceptance
  task automatic send_request(logic [2:0] mode, logic [4:0] index, logic [31:0] value);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i <= mode;
    in_index_i <= index;
    in_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // drops valid and waits until every pending result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] limit);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // failing requests on an empty list, two unused modes included
  task automatic test_empty_list();
    send_request(ModePop, 5'd0, 32'h0);
    send_request(ModeGet, 5'd0, 32'h0);
    send_request(ModeSet, 5'd0, 32'hFFFF_FFFF);
    send_request(ModeDelete, 5'd0, 32'h0);
    send_request(ModeDelete + 3'd1, 5'd31, 32'hFFFF_FFFF);
    send_request(ModeTop, 5'd31, 32'h1234_5678);
  endtask

  // append up to a small capacity, then one append on the full list
  task automatic test_fill_to_capacity();
    write_capacity(5'd3);
    send_request(ModeAppend, 5'd31, 32'h0000_0000);
    send_request(ModeAppend, 5'd0, 32'hFFFF_FFFF);
    send_request(ModeAppend, 5'd0, 32'hA5A5_A5A5);
    send_request(ModeAppend, 5'd0, 32'h5A5A_5A5A);
  endtask

  // reads at the first and last entry, a set in the middle, and accesses at count and far out of range
  task automatic test_index_access();
    send_request(ModeGet, 5'd0, 32'h0);
    send_request(ModeGet, 5'd2, 32'h0);
    send_request(ModeSet, 5'd1, 32'h5A5A_5A5A);
    send_request(ModeGet, 5'd1, 32'h0);
    send_request(ModeGet, 5'd3, 32'h0);
    send_request(ModeSet, 5'd31, 32'hDEAD_BEEF);
  endtask

  // delete at the head shifts the rest down, then a delete far out of range
  task automatic test_delete_compaction();
    send_request(ModeDelete, 5'd0, 32'h0);
    send_request(ModeGet, 5'd0, 32'h0);
    send_request(ModeDelete, 5'd31, 32'h0);
  endtask

  // capacity lowered below the count, then capacity zero
  task automatic test_capacity_changes();
    write_capacity(5'd1);
    send_request(ModeAppend, 5'd0, 32'h1111_1111);
    send_request(ModePop, 5'd0, 32'h0);
    send_request(ModePop, 5'd0, 32'h0);
    send_request(ModeAppend, 5'd0, 32'h8000_0001);
    send_request(ModeAppend, 5'd0, 32'h7FFF_FFFE);
    write_capacity(5'd0);
    send_request(ModePop, 5'd0, 32'h0);
    send_request(ModeAppend, 5'd0, 32'hFFFF_FFFF);
  endtask

  // random requests under a range of capacity settings
  task automatic test_random_traffic();
    logic [4:0]  caps [7];
    logic [2:0]  mode;
    logic [4:0]  index;
    int unsigned pick;
    caps = '{5'd16, 5'd31, 5'd2, 5'd1, 5'd17, 5'd0, 5'd0};
    caps[6] = 5'($urandom_range(0, 31));
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      steady = (p == 1);
      repeat (ItemsPerPhase) begin
        pick = $urandom_range(0, 99);
        if (pick < 32) mode = ModeAppend;
        else if (pick < 52) mode = ModeGet;
        else if (pick < 66) mode = ModeSet;
        else if (pick < 78) mode = ModePop;
        else if (pick < 94) mode = ModeDelete;
        else mode = 3'($urandom_range(ModeDelete + 1, ModeTop));
        // mostly indexes inside the list, some anywhere
        if (list_count > 0 && $urandom_range(0, 99) < 85)
          index = 5'($urandom_range(0, list_count - 1));
        else
          index = 5'($urandom_range(0, 31));
        send_request(mode, index, $urandom());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_empty_list();
    test_fill_to_capacity();
    test_index_access();
    test_delete_compaction();
    test_capacity_changes();
    test_random_traffic();
    wait_drained();
    if (pending_results.size() != 0)
      report_mismatch("requests left without result", pending_results.size(), '0);
    $display("Sent %0d requests, checked %0d results, %0d of them failed requests.",
             requests_sent, results_seen, fails_seen);
    $display("Capacity settings ran from zero through full depth to above depth.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
